/* src/matrix_multiply_element_assert.svh */
// ----------------------------------------------------------------------------
// matrix_multiply_element_assert.svh
// Assertion macros used by the matrix multiply element RTL (mme_ctrl).
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ELEMENT_ASSERT_SVH
`define MATRIX_MULTIPLY_ELEMENT_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define MME_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset
`define MME_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* src/mme_pkg.sv */
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants, command codes and types of the matrix multiply element.
// ----------------------------------------------------------------------------
package mme_pkg;

   // Fixed field widths of the request and response transfers
   localparam int COMMAND_BITS = 2;
   localparam int INDEX_BITS   = 10;
   localparam int VALUE_BITS   = 16;
   localparam int PRODUCT_BITS = 37;

   // Default sizes
   localparam int DIM_DEFAULT       = 32;
   localparam int ELEM_BITS_DEFAULT = 16;

   // Command codes
   localparam logic [COMMAND_BITS-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_COMPUTE = 2'd2;

   // One step handed from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

/* src/matrix_multiply_element.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_element
// Write commands leave the sequencer in IDLE. A compute walks DIV, FIX, RUN,
// DRAIN and DONE before its response is registered and accepts no new request
// until back in IDLE; the single multiply-accumulate walks the row of A and
// the column of B one element a cycle. Out-of-range compute: zero product.
// Reset clears the sequencer and response valid; A and B are undefined until
// written, and reset takes no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply_element
   import mme_pkg::*;
#(
   parameter int DIM       = DIM_DEFAULT,
   parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COMMAND_BITS-1:0] req_command,
   input  logic [INDEX_BITS-1:0]   req_index,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [INDEX_BITS-1:0]   rsp_result_index,
   output logic signed [PRODUCT_BITS-1:0] rsp_product
);

   localparam int CELLS = DIM * DIM;
   localparam int AW    = $clog2(CELLS);

   logic                    a_wr_en;
   logic                    b_wr_en;
   logic [AW-1:0]           wr_addr;
   logic [ELEM_BITS-1:0]    wr_data;
   logic [AW-1:0]           a_rd_addr;
   logic [AW-1:0]           b_rd_addr;
   logic [ELEM_BITS-1:0]    a_rd_data;
   logic [ELEM_BITS-1:0]    b_rd_data;
   mac_ctl_type             mac_ctl;
   logic [PRODUCT_BITS-1:0] mac_acc;
   logic                    mac_done;

   // Sequencer and response register
   mme_ctrl #(
      .DIM       (DIM),
      .ELEM_BITS (ELEM_BITS),
      .CELLS     (CELLS),
      .AW        (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_index (rsp_result_index),
      .rsp_product      (rsp_product),
      .a_wr_en          (a_wr_en),
      .b_wr_en          (b_wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .a_rd_addr        (a_rd_addr),
      .b_rd_addr        (b_rd_addr),
      .mac_ctl          (mac_ctl),
      .mac_acc          (mac_acc),
      .mac_done         (mac_done)
   );

   // Matrix A
   mme_store #(
      .DEPTH (CELLS),
      .WIDTH (ELEM_BITS),
      .AW    (AW)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   // Matrix B
   mme_store #(
      .DEPTH (CELLS),
      .WIDTH (ELEM_BITS),
      .AW    (AW)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // Shared multiply-accumulate
   mme_mac #(
      .ELEM_BITS (ELEM_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a_data (a_rd_data),
      .b_data (b_rd_data),
      .acc    (mac_acc),
      .done   (mac_done)
   );

endmodule

/* src/mme_store.sv */
// ----------------------------------------------------------------------------
// mme_store
// Single-port-write, single-port-read element memory with registered read.
// ----------------------------------------------------------------------------
module mme_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one element, read one element per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mme_mac.sv */
// ----------------------------------------------------------------------------
// mme_mac
// Shared signed multiply-accumulate: one register after the multiplier,
// one accumulator kept modulo 2^PRODUCT_BITS.
// ----------------------------------------------------------------------------
module mme_mac
   import mme_pkg::*;
#(
   parameter int ELEM_BITS = ELEM_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctl_type             ctl,
   input  logic [ELEM_BITS-1:0]    a_data,
   input  logic [ELEM_BITS-1:0]    b_data,
   output logic [PRODUCT_BITS-1:0] acc,
   output logic                    done
);

   mac_ctl_type                   stage0_ff;
   mac_ctl_type                   stage1_ff;
   logic                          done_ff;
   logic signed [2*ELEM_BITS-1:0] prod_in;
   logic signed [2*ELEM_BITS-1:0] prod_ff;
   logic [PRODUCT_BITS-1:0]       prod_ext;
   logic [PRODUCT_BITS-1:0]       acc_in;
   logic [PRODUCT_BITS-1:0]       acc_ff;

   // Multiply the two elements that the memories just returned
   assign prod_in  = $signed(a_data) * $signed(b_data);
   assign prod_ext = PRODUCT_BITS'(prod_ff);
   assign acc_in   = stage1_ff.first ? prod_ext : acc_ff + prod_ext;

   // Advance the step controls alongside the memory read and the product
   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ff <= '0;
         stage1_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         stage0_ff <= ctl;
         stage1_ff <= stage0_ff;
         done_ff   <= stage1_ff.valid && stage1_ff.last;
      end
   end

   // Register the product, then accumulate it
   always_ff @(posedge clock) begin
      if (stage0_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (stage1_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

/* src/mme_ctrl.sv */
// ----------------------------------------------------------------------------
// mme_ctrl
// Request handling and sequencer: splits the index into row and column,
// walks row of A and column of B, and holds the response register.
// ----------------------------------------------------------------------------
`include "matrix_multiply_element_assert.svh"

module mme_ctrl
   import mme_pkg::*;
#(
   parameter int DIM       = DIM_DEFAULT,
   parameter int ELEM_BITS = ELEM_BITS_DEFAULT,
   parameter int CELLS     = DIM_DEFAULT * DIM_DEFAULT,
   parameter int AW        = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COMMAND_BITS-1:0] req_command,
   input  logic [INDEX_BITS-1:0]   req_index,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [INDEX_BITS-1:0]   rsp_result_index,
   output logic signed [PRODUCT_BITS-1:0] rsp_product,
   output logic                    a_wr_en,
   output logic                    b_wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [ELEM_BITS-1:0]    wr_data,
   output logic [AW-1:0]           a_rd_addr,
   output logic [AW-1:0]           b_rd_addr,
   output mac_ctl_type             mac_ctl,
   input  logic [PRODUCT_BITS-1:0] mac_acc,
   input  logic                    mac_done
);

   localparam int IB = INDEX_BITS;
   localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam logic [IB-1:0] RECIP  = IB'((1 << IB) / DIM);
   localparam logic [IB-1:0] DIM_IB = IB'(DIM);
   localparam logic [AW-1:0] DIM_AW = AW'(DIM);
   localparam logic [KW-1:0] K_LAST = KW'(DIM - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_FIX   = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [IB-1:0]           idx_ff, idx_in;
   logic [IB-1:0]           quot_ff, quot_in;
   logic [IB-1:0]           col_ff, col_in;
   logic [AW-1:0]           a_addr_ff, a_addr_in;
   logic [AW-1:0]           b_addr_ff, b_addr_in;
   logic [KW-1:0]           k_ff, k_in;
   logic                    zero_ff, zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IB-1:0]           rsp_index_ff, rsp_index_in;
   logic [PRODUCT_BITS-1:0] rsp_product_ff, rsp_product_in;

   logic                    accept;
   logic                    in_range;
   logic                    rsp_free;
   logic [2*IB-1:0]         quot_full;
   logic [2*IB-1:0]         row_base_full;
   logic [IB-1:0]           col_raw;
   logic [IB-1:0]           col_fixed;

   // Handshake and write path
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (32'(req_index) < CELLS);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign a_wr_en   = accept && in_range && (req_command == CMD_WRITE_A);
   assign b_wr_en   = accept && in_range && (req_command == CMD_WRITE_B);
   assign wr_addr   = AW'(req_index);
   assign wr_data   = ELEM_BITS'(req_value);

   // Row and column by reciprocal multiply with one correction step
   assign quot_full     = (2*IB)'(idx_ff) * (2*IB)'(RECIP);
   assign row_base_full = (2*IB)'(quot_ff) * (2*IB)'(DIM_IB);
   assign col_raw       = idx_ff - row_base_full[IB-1:0];
   assign col_fixed     = (col_raw >= DIM_IB) ? col_raw - DIM_IB : col_raw;

   // Step controls for the shared multiply-accumulate
   assign mac_ctl.valid = (state_ff == ST_RUN);
   assign mac_ctl.first = (k_ff == '0);
   assign mac_ctl.last  = (k_ff == K_LAST);
   assign a_rd_addr     = a_addr_ff;
   assign b_rd_addr     = b_addr_ff;

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      quot_in        = quot_ff;
      col_in         = col_ff;
      a_addr_in      = a_addr_ff;
      b_addr_in      = b_addr_ff;
      k_in           = k_ff;
      zero_in        = zero_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_index_in   = rsp_index_ff;
      rsp_product_in = rsp_product_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_COMPUTE)) begin
               idx_in  = req_index;
               zero_in = !in_range;
               state_in = in_range ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            quot_in  = quot_full[2*IB-1:IB];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            col_in    = col_fixed;
            a_addr_in = AW'(idx_ff - col_fixed);
            b_addr_in = AW'(col_fixed);
            k_in      = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            a_addr_in = a_addr_ff + AW'(1);
            b_addr_in = b_addr_ff + DIM_AW;
            k_in      = k_ff + KW'(1);
            if (k_ff == K_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_index_in   = idx_ff;
               rsp_product_in = zero_ff ? '0 : mac_acc;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         zero_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         zero_ff      <= zero_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      quot_ff        <= quot_in;
      col_ff         <= col_in;
      a_addr_ff      <= a_addr_in;
      b_addr_ff      <= b_addr_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_product_ff <= rsp_product_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_product      = rsp_product_ff;

   `MME_ASSERT(a_compute_starts, (accept && (req_command == CMD_COMPUTE) && in_range) |=> (state_ff == ST_DIV), "in-range compute did not start the split")
   `MME_ASSERT(a_done_holds, ((state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready) |=> ((state_ff == ST_DONE) && $stable(rsp_index_ff)), "pending response overwritten")
   `MME_NEVER(a_done_outside_drain, mac_done && (state_ff != ST_DRAIN), "accumulator finished outside drain")
   `MME_ASSERT(a_col_range, (state_ff == ST_RUN) |-> (col_ff < DIM_IB), "column out of range during walk")

endmodule
